@@ rtl/psip_pkg.sv @@
// ----------------------------------------------------------------------------
// psip_pkg
// Shared types and constants of the partial shuffle index picker.
// ----------------------------------------------------------------------------
package psip_pkg;

   // result field widths
   localparam int unsigned SLOT_W   = 10;
   localparam int unsigned FIELD_W  = 32;
   localparam int unsigned ERR_W    = 2;
   localparam int unsigned RSP_DATA_W = 48;

   // result codes
   localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
   localparam logic [ERR_W-1:0] ERR_RANGE = 2'd1;
   localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;

   // register map
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic REG_UPPER_BOUND = 1'b0;

   typedef struct packed {
      logic load;        // take the input item
      logic walk_start;  // set the walk counter to the newest pick
      logic rd_en;       // read one stored pick
      logic finish;      // store the pick and register the result
   } psip_cmd_type;

   typedef struct packed {
      logic full;
      logic out_of_range;
      logic pos_zero;
      logic walk_last;
      logic out_free;
   } psip_status_type;

endpackage

@@ rtl/psip_ram.sv @@
// ----------------------------------------------------------------------------
// psip_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module psip_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024,
   localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/psip_controller.sv @@
// ----------------------------------------------------------------------------
// psip_controller
// Sequencer: takes an item, checks it, walks the stored picks, finishes.
// ----------------------------------------------------------------------------
module psip_controller
   import psip_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  psip_status_type status,
   output psip_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_WALK,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.full || status.out_of_range || status.pos_zero) begin
               state_in = ST_FINISH;
            end else begin
               cmd.walk_start = 1'b1;
               state_in       = ST_WALK;
            end
         end
         ST_WALK: begin
            cmd.rd_en = 1'b1;
            if (status.walk_last) begin
               state_in = ST_DRAIN;
            end
         end
         // last read data lands here
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

endmodule

@@ rtl/psip_datapath.sv @@
// ----------------------------------------------------------------------------
// psip_datapath
// Position, running value, pick store walk, bound register and result stage.
// ----------------------------------------------------------------------------
module psip_datapath
   import psip_pkg::*;
#(
   parameter int unsigned MAX_PICKS  = 1024,
   parameter int unsigned INDEX_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   // configuration
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   // input item
   input  logic [FIELD_W-1:0]    req_tdata,
   input  logic                  req_tuser,
   // result item
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [ERR_W-1:0]      rsp_tuser,
   // control
   input  psip_cmd_type          cmd,
   output psip_status_type       status
);

   localparam int unsigned IDX_W  = (INDEX_BITS < FIELD_W) ? INDEX_BITS : FIELD_W;
   localparam int unsigned POS_W  = $clog2(MAX_PICKS + 1);
   localparam int unsigned ADDR_W = (MAX_PICKS > 1) ? $clog2(MAX_PICKS) : 1;
   localparam int unsigned CMP_W  = (IDX_W > POS_W) ? IDX_W : POS_W;
   localparam int unsigned PAD_W  = RSP_DATA_W - FIELD_W - SLOT_W;

   logic [CSR_DATA_W-1:0] upper_ff,   upper_in;
   logic [POS_W-1:0]      pos_ff,     pos_in;
   logic [IDX_W-1:0]      draw_ff,    draw_in;
   logic [IDX_W-1:0]      value_ff,   value_in;
   logic [ADDR_W-1:0]     cnt_ff,     cnt_in;
   logic [ADDR_W-1:0]     rd_idx_ff,  rd_idx_in;
   logic                  rd_live_ff, rd_live_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [FIELD_W-1:0]    rsp_pick_ff,  rsp_pick_in;
   logic [SLOT_W-1:0]     rsp_slot_ff,  rsp_slot_in;
   logic [ERR_W-1:0]      rsp_err_ff,   rsp_err_in;

   logic [IDX_W-1:0]      top;
   logic [IDX_W-1:0]      rd_data;
   logic                  full;
   logic                  out_of_range;
   logic                  csr_write;
   logic                  store_wr;

   assign top  = upper_ff[IDX_W-1:0];
   assign full = (pos_ff >= POS_W'(MAX_PICKS));
   assign out_of_range = (CMP_W'(draw_ff) < CMP_W'(pos_ff)) || (draw_ff >= top);

   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == REG_UPPER_BOUND) ? upper_ff : '0;

   assign store_wr = cmd.finish && !full && !out_of_range;

   psip_ram #(
      .WIDTH (IDX_W),
      .DEPTH (MAX_PICKS)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_wr),
      .wr_addr (pos_ff[ADDR_W-1:0]),
      .wr_data (value_ff),
      .rd_en   (cmd.rd_en),
      .rd_addr (cnt_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      upper_in     = upper_ff;
      pos_in       = pos_ff;
      draw_in      = draw_ff;
      value_in     = value_ff;
      cnt_in       = cnt_ff;
      rd_idx_in    = cnt_ff;
      rd_live_in   = cmd.rd_en;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_pick_in  = rsp_pick_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_err_in   = rsp_err_ff;

      if (csr_write && (csr_paddr[2] == REG_UPPER_BOUND)) begin
         upper_in = csr_pwdata;
      end

      if (cmd.load) begin
         draw_in  = req_tdata[IDX_W-1:0];
         value_in = req_tdata[IDX_W-1:0];
         if (req_tuser) begin
            pos_in = '0;
         end
      end

      if (cmd.walk_start) begin
         cnt_in = ADDR_W'(pos_ff - POS_W'(1));
      end else if (cmd.rd_en) begin
         cnt_in = cnt_ff - ADDR_W'(1);
      end

      // a match moves the value to the slot it was found in
      if (rd_live_ff && (value_ff == rd_data)) begin
         value_in = IDX_W'(rd_idx_ff);
      end

      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         if (full) begin
            rsp_pick_in = '0;
            rsp_slot_in = '0;
            rsp_err_in  = ERR_FULL;
         end else if (out_of_range) begin
            rsp_pick_in = '0;
            rsp_slot_in = SLOT_W'(pos_ff);
            rsp_err_in  = ERR_RANGE;
         end else begin
            rsp_pick_in = FIELD_W'(value_ff);
            rsp_slot_in = SLOT_W'(pos_ff);
            rsp_err_in  = ERR_OK;
            pos_in      = pos_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff     <= CSR_DATA_W'(1);
         pos_ff       <= '0;
         rd_live_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         upper_ff     <= upper_in;
         pos_ff       <= pos_in;
         rd_live_ff   <= rd_live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      draw_ff     <= draw_in;
      value_ff    <= value_in;
      cnt_ff      <= cnt_in;
      rd_idx_ff   <= rd_idx_in;
      rsp_pick_ff <= rsp_pick_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign status.full         = full;
   assign status.out_of_range = out_of_range;
   assign status.pos_zero     = (pos_ff == '0);
   assign status.walk_last    = (cnt_ff == '0);
   assign status.out_free     = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, rsp_slot_ff, rsp_pick_ff};
   assign rsp_tuser  = rsp_err_ff;

endmodule

@@ rtl/partial_shuffle_index_picker_unit.sv @@
// ----------------------------------------------------------------------------
// partial_shuffle_index_picker_unit
// Partial Fisher-Yates index picker fed by external random draws.
// ----------------------------------------------------------------------------
// Each item brings a draw in [position, upper_bound) and yields one result:
// a distinct index, the slot it went into and a status code. The stored
// picks are read back one per cycle from the pick store RAM, newest first.
// An accepted item passes the check, walk, drain and finish states (walk
// and drain are skipped when position is zero), and the next item is taken
// the cycle after the result is registered; an item that fails the full or
// range check goes from check straight to finish. The result register
// lets the next item in while a result still waits. Restart in tuser
// clears the position before the draw is handled. upper_bound sits at
// byte address 0 and resets to 1; write it only while no item is in flight.
module partial_shuffle_index_picker_unit
   import psip_pkg::*;
#(
   parameter int unsigned MAX_PICKS  = 1024,
   parameter int unsigned INDEX_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   // input items
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [FIELD_W-1:0]    req_tdata,   // [31:0] random_draw
   input  logic                  req_tuser,   // [0] restart
   // result items
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [31:0] picked_index, [41:32] slot_number
   output logic [ERR_W-1:0]      rsp_tuser,   // [1:0] error_code
   // configuration
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   psip_cmd_type    cmd;
   psip_status_type status;

   assign csr_pready = 1'b1;

   psip_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   psip_datapath #(
      .MAX_PICKS  (MAX_PICKS),
      .INDEX_BITS (INDEX_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .cmd         (cmd),
      .status      (status)
   );

endmodule
